/* hdl/bmp_pixel_unpacker_defines.svh */
// Assertion macros shared by the BMP pixel unpacker RTL.
// Each macro expects i_clk and i_rst_n to exist in the module that uses it.
`ifndef BMP_PIXEL_UNPACKER_DEFINES_SVH
`define BMP_PIXEL_UNPACKER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BPU_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BPU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bpu_pkg.sv */
// Package of the BMP pixel unpacker: sizes, codes and the structs that
// travel between the register, front and expander modules. No dependencies.
`default_nettype none

package bpu_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int PAL_DEPTH  = 256;
    localparam int PAL_AW     = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
    localparam int CFG_AW     = 5;

    // Pixel format codes.
    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_4BPP  = 3'd1;
    localparam logic [2:0] FMT_8BPP  = 3'd2;
    localparam logic [2:0] FMT_24BPP = 3'd3;
    localparam logic [2:0] FMT_32BPP = 3'd4;

    // Register indexes (word address).
    localparam logic [2:0] REG_FORMAT    = 3'd0;
    localparam logic [2:0] REG_WIDTH     = 3'd1;
    localparam logic [2:0] REG_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_BOTTOM_UP = 3'd3;
    localparam logic [2:0] REG_PAL_COUNT = 3'd4;

    // Input word actions.
    localparam logic ACT_PALETTE = 1'b0;
    localparam logic ACT_DATA    = 1'b1;

    localparam logic [23:0] COLOR_WHITE  = 24'hffffff;
    localparam logic [23:0] COLOR_BLACK  = 24'h000000;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

    typedef struct packed {
        logic [2:0]  fmt;
        logic [12:0] width;
        logic [12:0] height;
        logic        bottom_up;
        logic [8:0]  pal_count;
    } t_cfg;

    // One accepted word after decode: a palette write or a data byte that
    // yields at least one pixel.
    typedef struct packed {
        logic        is_wr;
        logic [2:0]  fmt;
        logic [7:0]  data;      // data byte, or palette index for a write
        logic [23:0] color;     // assembled direct color, or palette color
        logic [7:0]  alpha;
        logic [3:0]  npix;
        logic [11:0] col;
        logic [11:0] y;
        logic        last_row;
        logic [11:0] w_last;
    } t_job;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [23:0] color;
        logic        use_pal;
        logic [7:0]  alpha;
        logic        run_end;
        logic        image_end;
    } t_pix;

    function automatic logic [12:0] f_clamp_size(input logic [12:0] v, input logic [12:0] hi);
        logic [12:0] r;
        r = v;
        if (v == 13'd0) begin
            r = 13'd1;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/bpu_regs.sv */
// Configuration registers of the BMP pixel unpacker behind an APB-style port.
// Depends on bpu_pkg for register indexes and the t_cfg struct.
`default_nettype none

module bpu_regs import bpu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt       <= FMT_8BPP;
            r_cfg.width     <= 13'd1;
            r_cfg.height    <= 13'd1;
            r_cfg.bottom_up <= 1'b1;
            r_cfg.pal_count <= 9'd0;
        end else if (wr_en) begin
            unique case (paddr[CFG_AW-1:2])
                REG_FORMAT:    r_cfg.fmt       <= pwdata[2:0];
                REG_WIDTH:     r_cfg.width     <= pwdata[12:0];
                REG_HEIGHT:    r_cfg.height    <= pwdata[12:0];
                REG_BOTTOM_UP: r_cfg.bottom_up <= pwdata[0];
                REG_PAL_COUNT: r_cfg.pal_count <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[CFG_AW-1:2])
            REG_FORMAT:    prdata = {29'd0, r_cfg.fmt};
            REG_WIDTH:     prdata = {19'd0, r_cfg.width};
            REG_HEIGHT:    prdata = {19'd0, r_cfg.height};
            REG_BOTTOM_UP: prdata = {31'd0, r_cfg.bottom_up};
            REG_PAL_COUNT: prdata = {23'd0, r_cfg.pal_count};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/bpu_front.sv */
// Front stage: accepts input words, keeps the row and column counters and
// the partial pixel bytes, and hands decoded jobs to the expander.
// Depends on bpu_pkg.
`default_nettype none

module bpu_front import bpu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    input  logic        i_action,
    input  logic [7:0]  i_palette_index,
    input  logic [23:0] i_palette_color,
    input  logic [7:0]  i_data_byte,
    input  logic        i_job_free,
    output logic        o_ready,
    output logic        o_job_v,
    output t_job        o_job
);

    logic [12:0] r_col;
    logic [11:0] r_row;
    logic [13:0] r_rbc;
    logic [23:0] r_pp;
    logic [1:0]  r_pbc;

    logic [12:0] n_col;
    logic [11:0] n_row;
    logic [13:0] n_rbc;
    logic [23:0] n_pp;
    logic [1:0]  n_pbc;

    logic        accept, valid_fmt, upd, row_end;
    logic [12:0] w, h, rem, y_full, row_inc;
    logic [17:0] bits, bits_rnd;
    logic [14:0] stride, rbc_inc;
    logic [11:0] row_eff;
    logic [23:0] ins, color;
    logic [7:0]  alpha;
    logic [3:0]  npix;

    assign o_ready   = i_job_free;
    assign accept    = i_valid && i_job_free;
    assign valid_fmt = (i_cfg.fmt <= FMT_32BPP);
    assign upd       = accept && (i_action == ACT_DATA) && valid_fmt;

    // Row stride in bytes, rounded up to whole 32-bit words.
    always_comb begin
        w = f_clamp_size(i_cfg.width, 13'(MAX_WIDTH));
        h = f_clamp_size(i_cfg.height, 13'(MAX_HEIGHT));
        case (i_cfg.fmt)
            FMT_1BPP:  bits = {5'd0, w};
            FMT_4BPP:  bits = {3'd0, w, 2'd0};
            FMT_8BPP:  bits = {2'd0, w, 3'd0};
            FMT_24BPP: bits = {1'b0, w, 4'd0} + {2'd0, w, 3'd0};
            default:   bits = {w, 5'd0};
        endcase
        bits_rnd = bits + 18'd31;
        stride   = {bits_rnd[17:5], 2'b00};
    end

    always_comb begin
        row_eff = ({1'b0, r_row} >= h) ? 12'd0 : r_row;
        rbc_inc = {1'b0, r_rbc} + 15'd1;
        row_end = (rbc_inc >= stride);
        rem     = w - r_col;
        case (r_pbc)
            2'd0:    ins = {16'd0, i_data_byte};
            2'd1:    ins = {8'd0, i_data_byte, 8'd0};
            2'd2:    ins = {i_data_byte, 16'd0};
            default: ins = 24'd0;
        endcase

        npix  = 4'd0;
        color = r_pp;
        alpha = ALPHA_OPAQUE;
        n_pp  = r_pp;
        n_pbc = r_pbc;
        if (r_col < w) begin
            case (i_cfg.fmt)
                FMT_1BPP: npix = (rem >= 13'd8) ? 4'd8 : rem[3:0];
                FMT_4BPP: npix = (rem >= 13'd2) ? 4'd2 : rem[3:0];
                FMT_8BPP: npix = 4'd1;
                FMT_24BPP: begin
                    color = r_pp | ins;
                    // The third byte completes the pixel.
                    if (r_pbc >= 2'd2) begin
                        npix  = 4'd1;
                        n_pp  = 24'd0;
                        n_pbc = 2'd0;
                    end else begin
                        n_pp  = r_pp | ins;
                        n_pbc = r_pbc + 2'd1;
                    end
                end
                FMT_32BPP: begin
                    // The fourth byte is alpha and completes the pixel.
                    if (r_pbc == 2'd3) begin
                        npix  = 4'd1;
                        alpha = i_data_byte;
                        n_pp  = 24'd0;
                        n_pbc = 2'd0;
                    end else begin
                        n_pp  = r_pp | ins;
                        n_pbc = r_pbc + 2'd1;
                    end
                end
                default: ;
            endcase
        end

        n_col   = r_col + {9'd0, npix};
        n_row   = row_eff;
        n_rbc   = rbc_inc[13:0];
        row_inc = {1'b0, row_eff} + 13'd1;
        if (row_end) begin
            n_rbc = 14'd0;
            n_col = 13'd0;
            n_pp  = 24'd0;
            n_pbc = 2'd0;
            n_row = (row_inc >= h) ? 12'd0 : row_inc[11:0];
        end

        y_full = i_cfg.bottom_up ? (h - 13'd1 - {1'b0, row_eff}) : {1'b0, row_eff};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 13'd0;
            r_row <= 12'd0;
            r_rbc <= 14'd0;
            r_pp  <= 24'd0;
            r_pbc <= 2'd0;
        end else if (upd) begin
            r_col <= n_col;
            r_row <= n_row;
            r_rbc <= n_rbc;
            r_pp  <= n_pp;
            r_pbc <= n_pbc;
        end
    end

    always_comb begin
        o_job_v = accept && ((i_action == ACT_PALETTE) || (valid_fmt && (npix != 4'd0)));
        o_job.is_wr    = (i_action == ACT_PALETTE);
        o_job.fmt      = i_cfg.fmt;
        o_job.data     = (i_action == ACT_PALETTE) ? i_palette_index : i_data_byte;
        o_job.color    = (i_action == ACT_PALETTE) ? i_palette_color : color;
        o_job.alpha    = alpha;
        o_job.npix     = npix;
        o_job.col      = r_col[11:0];
        o_job.y        = y_full[11:0];
        o_job.last_row = ({1'b0, row_eff} == (h - 13'd1));
        o_job.w_last   = 12'(w - 13'd1);
    end

endmodule

`default_nettype wire

/* hdl/bpu_expand.sv */
// Expander: holds one job, steps through its pixels one per cycle unless stalled,
// reads and writes the palette memory, resolves colors and drives the output register.
// Depends on bpu_pkg and the assertion macros.
`default_nettype none

module bpu_expand import bpu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_job_v,
    input  t_job        i_job,
    output logic        o_job_free,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_pixel_x,
    output logic [11:0] o_pixel_y,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic        o_run_end,
    output logic        o_image_end
);

    logic [23:0] r_palette [PAL_DEPTH];

    logic        r_job_v;
    t_job        r_job;
    logic [2:0]  r_k;
    logic        r_s1_v;
    t_pix        r_s1;
    logic [23:0] r_rdata;
    logic        r_o_v;
    t_pix        r_o;

    logic        o_adv, s1_adv, s1_free, issue, last_k, job_done, rd_en, wr_en, cand;
    logic [7:0]  idx;
    logic [3:0]  nib;
    logic [23:0] fallback;
    logic [12:0] x_sum;
    t_pix        pix;
    t_pix        s1_out;

    // Stage handshakes. Reads and palette writes issue in stream order from
    // the single job slot, so a read never overlaps a write to the memory.
    assign o_adv      = !r_o_v || i_ready;
    assign s1_adv     = r_s1_v && o_adv;
    assign s1_free    = !r_s1_v || o_adv;
    assign issue      = r_job_v && (r_job.is_wr || s1_free);
    assign last_k     = r_job.is_wr || ({1'b0, r_k} == (r_job.npix - 4'd1));
    assign job_done   = issue && last_k;
    assign o_job_free = !r_job_v || job_done;
    assign rd_en      = issue && !r_job.is_wr;
    assign wr_en      = issue && r_job.is_wr && ({1'b0, r_job.data} < 9'(PAL_DEPTH));

    always_comb begin
        nib = (r_k == 3'd0) ? r_job.data[7:4] : r_job.data[3:0];
        case (r_job.fmt)
            FMT_1BPP: begin
                idx      = {7'd0, r_job.data[3'd7 - r_k]};
                fallback = idx[0] ? COLOR_WHITE : COLOR_BLACK;
                cand     = 1'b1;
            end
            FMT_4BPP: begin
                idx      = {4'd0, nib};
                fallback = {idx, idx, idx};
                cand     = 1'b1;
            end
            FMT_8BPP: begin
                idx      = r_job.data;
                fallback = {idx, idx, idx};
                cand     = 1'b1;
            end
            default: begin
                idx      = 8'd0;
                fallback = r_job.color;
                cand     = 1'b0;
            end
        endcase
        x_sum         = {1'b0, r_job.col} + {10'd0, r_k};
        pix.x         = x_sum[11:0];
        pix.y         = r_job.y;
        pix.color     = fallback;
        pix.use_pal   = cand && ({1'b0, idx} < i_cfg.pal_count)
                        && ({1'b0, idx} < 9'(PAL_DEPTH));
        pix.alpha     = r_job.alpha;
        pix.run_end   = last_k;
        pix.image_end = r_job.last_row && (x_sum[11:0] == r_job.w_last);
    end

    // Stage one: the palette word replaces the fallback color when use_pal is set.
    always_comb begin
        s1_out         = r_s1;
        s1_out.color   = r_s1.use_pal ? r_rdata : r_s1.color;
        s1_out.use_pal = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_v <= 1'b0;
            r_k     <= 3'd0;
        end else if (o_job_free) begin
            r_job_v <= i_job_v;
            r_k     <= 3'd0;
        end else if (issue) begin
            r_k <= r_k + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_free && i_job_v) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_palette[r_job.data[PAL_AW-1:0]] <= r_job.color;
        end
        if (rd_en) begin
            r_rdata <= r_palette[idx[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= rd_en;
            end
            if (o_adv) begin
                r_o_v <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1 <= pix;
        end
        if (s1_adv) begin
            r_o <= s1_out;
        end
    end

    assign o_valid     = r_o_v;
    assign o_pixel_x   = r_o.x;
    assign o_pixel_y   = r_o.y;
    assign o_red       = r_o.color[23:16];
    assign o_green     = r_o.color[15:8];
    assign o_blue      = r_o.color[7:0];
    assign o_alpha     = r_o.alpha;
    assign o_run_end   = r_o.run_end;
    assign o_image_end = r_o.image_end;

`include "bmp_pixel_unpacker_defines.svh"

    `BPU_ASSERT(a_job_has_pixels, r_job_v && !r_job.is_wr, r_job.npix != 4'd0, "empty data job")
    `BPU_ASSERT(a_k_in_range, r_job_v && !r_job.is_wr, ({1'b0, r_k} < r_job.npix), "pixel step past job")
    `BPU_ASSERT_NEXT(a_rdata_hold, r_s1_v && !o_adv, $stable(r_rdata), "palette data lost in stall")
    `BPU_ASSERT(a_end_is_run_end, r_o_v && r_o.image_end, r_o.run_end, "image end not last of byte")

endmodule

`default_nettype wire

/* hdl/bmp_pixel_unpacker.sv */
// Top level of the BMP pixel unpacker: registers, front stage and expander.
// Depends on bpu_pkg, bpu_regs, bpu_front and bpu_expand.
//
//  channel  direction  handshake                 word
//  input    in         i_in_valid / o_in_ready   action, palette index/color, data byte
//  output   out        o_out_valid / i_out_ready pixel x, y, RGBA, run_end, image_end
//  config   in         psel/penable/pwrite       APB-style, pready always high
//
// A byte that yields n pixels holds the expander until all n are issued (1bpp up to 8,
// 4bpp up to 2); other jobs need a single issue, so 8, 24 and 32 bpp run at one byte
// per cycle while the output does not stall. The figure is set by the single palette
// read port, one lookup per cycle. Pixels pass the job, stage-one and output registers.
// Reset is synchronous and clears counters and valid flags; the palette is not cleared.
// A stall on the output backs up through the expander to o_in_ready.
`default_nettype none

module bmp_pixel_unpacker import bpu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_action,
    input  logic [7:0]        i_palette_index,
    input  logic [23:0]       i_palette_color,
    input  logic [7:0]        i_data_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [11:0]       o_pixel_x,
    output logic [11:0]       o_pixel_y,
    output logic [7:0]        o_red,
    output logic [7:0]        o_green,
    output logic [7:0]        o_blue,
    output logic [7:0]        o_alpha,
    output logic              o_run_end,
    output logic              o_image_end
);

    t_cfg cfg;
    logic job_v, job_free;
    t_job job;

    bpu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bpu_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (i_in_valid),
        .i_action        (i_action),
        .i_palette_index (i_palette_index),
        .i_palette_color (i_palette_color),
        .i_data_byte     (i_data_byte),
        .i_job_free      (job_free),
        .o_ready         (o_in_ready),
        .o_job_v         (job_v),
        .o_job           (job)
    );

    bpu_expand u_expand (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_v     (job_v),
        .i_job       (job),
        .o_job_free  (job_free),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue),
        .o_alpha     (o_alpha),
        .o_run_end   (o_run_end),
        .o_image_end (o_image_end)
    );

endmodule

`default_nettype wire
